// ----- rtl/gbbig5_pkg.sv -----
// Package for the GB2312 / Big5 stream transcoder.
// Holds code-table geometry, mapping constants and shared types; no dependencies.
`default_nettype none

package gbbig5_pkg;

   localparam int B2G_ENTRIES = 13973;
   localparam int G2B_ENTRIES = 7614;
   localparam int TABLE_DEPTH = B2G_ENTRIES + G2B_ENTRIES;
   localparam int ADDR_W      = 15;
   localparam int CODE_W      = 16;
   localparam int BYTE_W      = 8;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type RANGE_LO    = 8'ha1;
   localparam byte_type RANGE_HI    = 8'hfe;
   localparam byte_type GB_ROW_A_HI = 8'ha9;
   localparam byte_type GB_ROW_B_LO = 8'hb0;
   localparam byte_type GB_ROW_B_HI = 8'hf7;
   localparam byte_type B5_FIRST_HI = 8'hf9;
   localparam byte_type B5_LO_LO    = 8'h40;
   localparam byte_type B5_LO_HI    = 8'h7e;

   localparam int GB_ROW_LEN    = 94;
   localparam int GB_ROW_B_BASE = 9;
   localparam int B5_ROW_LEN    = 157;
   localparam int B5_HI_OFFSET  = 63;

   localparam code_type GB_BAD_CODE = 16'ha1bc;
   localparam code_type B5_BAD_CODE = 16'ha1f5;

   typedef enum logic {
      ACT_LOAD    = 1'b0,
      ACT_CONVERT = 1'b1
   } action_type;

   typedef enum logic {
      DIR_GB_TO_B5 = 1'b0,
      DIR_B5_TO_GB = 1'b1
   } direction_type;

   // item between the mapping stage and the output stage
   typedef struct packed {
      logic     valid;
      logic     use_ram;
      logic     two;
      logic     channel;
      code_type code;
      addr_type addr;
   } stage_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      code_type wr_data;
      addr_type rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

// ----- rtl/gbbig5_if.sv -----
// Channel interfaces of the transcoder: request (byte or table load) and response bytes.
// Depends on gbbig5_pkg.
`default_nettype none

interface gbbig5_req_if;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic                     direction;
   logic                     channel;
   gbbig5_pkg::byte_type     byte_in;
   gbbig5_pkg::addr_type     table_address;
   gbbig5_pkg::code_type     table_word;

   modport source (output valid, action, direction, channel, byte_in, table_address,
                   table_word, input ready);
   modport sink   (input valid, action, direction, channel, byte_in, table_address,
                   table_word, output ready);
endinterface

interface gbbig5_rsp_if;
   logic                 valid;
   logic                 ready;
   gbbig5_pkg::byte_type byte_out;
   logic                 channel_out;
   logic                 last_of_run;

   modport source (output valid, byte_out, channel_out, last_of_run, input ready);
   modport sink   (input valid, byte_out, channel_out, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/gb2312_big5_stream_transcoder.sv -----
// GB2312 <-> Big5 byte-stream transcoder, two channels per direction, table loaded by request.
// A byte that yields output passes the accept-stage register, then the output-stage register.
// One request per cycle unless the output stage stalls; a completed pair takes two transfers.
// Reset clears the pending bytes and the pipeline; the code table is not cleared.
// Depends on gbbig5_pkg, gbbig5_if, gbbig5_ram, gbbig5_front, gbbig5_back.
`default_nettype none

module gb2312_big5_stream_transcoder (
   input  wire logic    clock,
   input  wire logic    reset,
   gbbig5_req_if.sink   req_bus,
   gbbig5_rsp_if.source rsp_bus
);

   gbbig5_pkg::stage_type   s1_stage;
   gbbig5_pkg::ram_req_type ram_req;
   gbbig5_pkg::code_type    ram_rdata;
   logic                    space;

   gbbig5_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .space   (space),
      .stage   (s1_stage),
      .ram_req (ram_req)
   );

   gbbig5_ram #(
      .WIDTH (gbbig5_pkg::CODE_W),
      .DEPTH (gbbig5_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rdata)
   );

   gbbig5_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stage     (s1_stage),
      .ram_rdata (ram_rdata),
      .space     (space),
      .rsp       (rsp_bus)
   );

   a_write_only_on_transfer : assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (req_bus.valid && req_bus.ready))
      else $error("table write without a request transfer");

   a_stall_rereads_slot : assert property (@(posedge clock) disable iff (reset)
      (s1_stage.valid && !space) |-> (ram_req.rd_addr == s1_stage.addr))
      else $error("stalled item lost its table read");

   a_pair_second_byte : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_of_run)
      |=> (rsp_bus.valid && rsp_bus.last_of_run && $stable(rsp_bus.channel_out)))
      else $error("first byte of a pair not followed by its second byte");

endmodule

`default_nettype wire

// ----- rtl/gbbig5_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module gbbig5_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/gbbig5_front.sv -----
// Accept stage: pending-byte store, pair mapping to a table slot, table write/read requests.
// Depends on gbbig5_pkg and gbbig5_if.
`default_nettype none

module gbbig5_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   gbbig5_req_if.sink                   req,
   input  wire logic                    space,
   output gbbig5_pkg::stage_type        stage,
   output gbbig5_pkg::ram_req_type      ram_req
);

   gbbig5_pkg::byte_type  pend_ff [4];
   gbbig5_pkg::byte_type  pend_in [4];
   gbbig5_pkg::stage_type s1_ff;
   gbbig5_pkg::stage_type s1_in;

   logic [1:0]           sel;
   gbbig5_pkg::byte_type first;
   gbbig5_pkg::byte_type second;
   logic                 held;
   logic                 ready_w;
   logic                 accept;
   logic                 convert;
   logic [6:0]           gb_row;
   logic                 gb_ok;
   gbbig5_pkg::addr_type gb_slot;
   logic [6:0]           b5_row;
   logic                 b5_ok;
   gbbig5_pkg::addr_type b5_base;
   gbbig5_pkg::addr_type b5_slot;
   logic                 map_ok;
   gbbig5_pkg::addr_type slot;
   gbbig5_pkg::code_type bad_code;

   assign sel     = {req.direction, req.channel};
   assign first   = pend_ff[sel];
   assign second  = req.byte_in;
   assign held    = (first != '0);
   assign ready_w = !s1_ff.valid || space;
   assign accept  = req.valid && ready_w;
   assign convert = accept && (req.action == gbbig5_pkg::ACT_CONVERT);
   assign req.ready = ready_w;

   // GB2312 pair -> slot in the GB-to-Big5 half
   always_comb begin
      gb_row = '0;
      gb_ok  = 1'b0;
      if (second inside {[gbbig5_pkg::RANGE_LO:gbbig5_pkg::RANGE_HI]}) begin
         if (first inside {[gbbig5_pkg::RANGE_LO:gbbig5_pkg::GB_ROW_A_HI]}) begin
            gb_row = 7'(first - gbbig5_pkg::RANGE_LO);
            gb_ok  = 1'b1;
         end else if (first inside {[gbbig5_pkg::GB_ROW_B_LO:gbbig5_pkg::GB_ROW_B_HI]}) begin
            gb_row = 7'(first - gbbig5_pkg::GB_ROW_B_LO) + 7'(gbbig5_pkg::GB_ROW_B_BASE);
            gb_ok  = 1'b1;
         end
      end
      gb_slot = gbbig5_pkg::addr_type'(gbbig5_pkg::B2G_ENTRIES)
              + gbbig5_pkg::addr_type'(gb_row) * gbbig5_pkg::addr_type'(gbbig5_pkg::GB_ROW_LEN)
              + gbbig5_pkg::addr_type'(second - gbbig5_pkg::RANGE_LO);
   end

   // Big5 pair -> slot in the Big5-to-GB half
   always_comb begin
      b5_row  = 7'(first - gbbig5_pkg::RANGE_LO);
      b5_base = gbbig5_pkg::addr_type'(b5_row)
              * gbbig5_pkg::addr_type'(gbbig5_pkg::B5_ROW_LEN);
      b5_ok   = 1'b0;
      b5_slot = b5_base;
      if (first inside {[gbbig5_pkg::RANGE_LO:gbbig5_pkg::B5_FIRST_HI]}) begin
         if (second inside {[gbbig5_pkg::B5_LO_LO:gbbig5_pkg::B5_LO_HI]}) begin
            b5_slot = b5_base + gbbig5_pkg::addr_type'(second - gbbig5_pkg::B5_LO_LO);
            b5_ok   = 1'b1;
         end else if (second inside {[gbbig5_pkg::RANGE_LO:gbbig5_pkg::RANGE_HI]}) begin
            b5_slot = b5_base + gbbig5_pkg::addr_type'(second - gbbig5_pkg::RANGE_LO)
                    + gbbig5_pkg::addr_type'(gbbig5_pkg::B5_HI_OFFSET);
            b5_ok   = 1'b1;
         end
      end
   end

   always_comb begin
      if (req.direction == gbbig5_pkg::DIR_GB_TO_B5) begin
         map_ok   = gb_ok;
         slot     = gb_slot;
         bad_code = gbbig5_pkg::GB_BAD_CODE;
      end else begin
         map_ok   = b5_ok;
         slot     = b5_slot;
         bad_code = gbbig5_pkg::B5_BAD_CODE;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (convert) begin
         if (held) begin
            pend_in[sel] = '0;
         end else if (second[7]) begin
            pend_in[sel] = second;
         end
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (ready_w) begin
         s1_in.valid   = convert && (held || !second[7]);
         s1_in.use_ram = held && map_ok;
         s1_in.two     = held;
         s1_in.channel = req.channel;
         s1_in.code    = held ? bad_code : {8'h00, second};
         s1_in.addr    = slot;
      end
   end

   // a stalled item re-reads its own slot so the registered data stays current
   always_comb begin
      ram_req.wr_en   = accept && (req.action == gbbig5_pkg::ACT_LOAD)
                      && (req.table_address < gbbig5_pkg::addr_type'(gbbig5_pkg::TABLE_DEPTH));
      ram_req.wr_addr = req.table_address;
      ram_req.wr_data = req.table_word;
      ram_req.rd_addr = accept ? slot : s1_ff.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pend_ff[i] <= '0;
         end
         s1_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         s1_ff   <= s1_in;
      end
   end

   assign stage = s1_ff;

endmodule

`default_nettype wire

// ----- rtl/gbbig5_back.sv -----
// Output stage: holds one converted code and sends it as one or two byte transfers.
// Depends on gbbig5_pkg and gbbig5_if.
`default_nettype none

module gbbig5_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gbbig5_pkg::stage_type stage,
   input  wire gbbig5_pkg::code_type  ram_rdata,
   output logic                       space,
   gbbig5_rsp_if.source               rsp
);

   logic [1:0]           cnt_ff;
   logic [1:0]           cnt_in;
   gbbig5_pkg::code_type code_ff;
   gbbig5_pkg::code_type code_in;
   logic                 chan_ff;
   logic                 chan_in;
   logic                 take;
   logic                 sent;

   assign sent  = rsp.valid && rsp.ready;
   assign space = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp.ready);
   assign take  = stage.valid && space;

   always_comb begin
      cnt_in  = cnt_ff;
      code_in = code_ff;
      chan_in = chan_ff;
      if (take) begin
         cnt_in  = stage.two ? 2'd2 : 2'd1;
         code_in = stage.use_ram ? ram_rdata : stage.code;
         chan_in = stage.channel;
      end else if (sent) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      code_ff <= code_in;
      chan_ff <= chan_in;
   end

   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.byte_out    = (cnt_ff == 2'd2) ? code_ff[15:8] : code_ff[7:0];
   assign rsp.channel_out = chan_ff;
   assign rsp.last_of_run = (cnt_ff == 2'd1);

endmodule

`default_nettype wire
